/* rtl/core/cte_pkg.sv */
package cte_pkg;

   // Sizes of the running counters and of the option register.
   localparam int MAX_LEN = 4096;
   localparam int POS_W = $clog2(MAX_LEN + 1);
   localparam int OPT_W = 7;

   // Results that one source byte can cause at most, and the queue of result packets.
   localparam int MAX_RES = 4;
   localparam int RES_IDX_W = $clog2(MAX_RES);
   localparam int RES_CNT_W = $clog2(MAX_RES + 1);
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   // Bit positions within the option register.
   localparam int OPT_KEEP_WS = 0;
   localparam int OPT_KEEP_HASH = 1;
   localparam int OPT_STOP_EQUALS = 2;
   localparam int OPT_KEEP_SEMI = 3;
   localparam int OPT_PATTERN_STOP = 4;
   localparam int OPT_NO_QUOTES = 5;
   localparam int OPT_CARET = 6;

   // Result kinds.
   localparam logic KIND_DATA = 1'b0;
   localparam logic KIND_END = 1'b1;

   // Character codes.
   localparam logic [7:0] CH_NUL = 8'h00;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB = 8'h09;
   localparam logic [7:0] CH_LF = 8'h0a;
   localparam logic [7:0] CH_FF = 8'h0c;
   localparam logic [7:0] CH_CR = 8'h0d;
   localparam logic [7:0] CH_ESCAPE = 8'h1b;
   localparam logic [7:0] CH_HASH = 8'h23;
   localparam logic [7:0] CH_SEMI = 8'h3b;
   localparam logic [7:0] CH_EQUALS = 8'h3d;
   localparam logic [7:0] CH_TILDE = 8'h7e;
   localparam logic [7:0] CH_BANG = 8'h21;
   localparam logic [7:0] CH_PIPE = 8'h7c;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_BACKSLASH = 8'h5c;
   localparam logic [7:0] CH_CARET = 8'h5e;
   localparam logic [7:0] CH_LBRACKET = 8'h5b;
   localparam logic [7:0] CH_AT = 8'h40;
   localparam logic [7:0] CH_LOW_X = 8'h78;
   localparam logic [7:0] CTRL_MASK = 8'h7f;
   localparam logic [13:0] OCT_BIAS = 14'd3504;

   // Parser phases, one-hot.
   typedef enum logic [10:0] {
      PH_LEAD  = 11'b000_0000_0001,
      PH_BODY  = 11'b000_0000_0010,
      PH_ESC   = 11'b000_0000_0100,
      PH_CTRLC = 11'b000_0000_1000,
      PH_OCT1  = 11'b000_0001_0000,
      PH_OCT2  = 11'b000_0010_0000,
      PH_HEX1  = 11'b000_0100_0000,
      PH_HEX2  = 11'b000_1000_0000,
      PH_CARET = 11'b001_0000_0000,
      PH_TRAIL = 11'b010_0000_0000,
      PH_DONE  = 11'b100_0000_0000
   } phase_type;

   typedef enum logic [1:0] {
      Q_NONE   = 2'd0,
      Q_SINGLE = 2'd1,
      Q_DOUBLE = 2'd2
   } quote_type;

   typedef struct packed {
      logic             kind;
      logic [7:0]       data;
      logic [POS_W-1:0] consumed;
   } result_type;

   typedef struct packed {
      logic [RES_CNT_W-1:0]          count;
      result_type [MAX_RES-1:0]      res;
   } packet_type;

   typedef struct packed {
      logic       valid;
      packet_type pkt;
   } head_type;

   function automatic logic is_ws(logic [7:0] b);
      return (b == CH_SPACE) || (b inside {[CH_TAB:CH_CR]});
   endfunction

   function automatic logic is_oct(logic [7:0] b);
      return b inside {["0":"7"]};
   endfunction

   function automatic logic is_dec(logic [7:0] b);
      return b inside {["0":"9"]};
   endfunction

   function automatic logic is_hex(logic [7:0] b);
      return b inside {["0":"9"], ["a":"f"], ["A":"F"]};
   endfunction

   function automatic logic is_alpha(logic [7:0] b);
      return b inside {["a":"z"], ["A":"Z"]};
   endfunction

   function automatic logic [3:0] hex_val(logic [7:0] b);
      logic [7:0] v;
      if (b inside {["0":"9"]}) begin
         v = b - 8'("0");
      end else if (b inside {["a":"f"]}) begin
         v = b - 8'("a") + 8'd10;
      end else begin
         v = b - 8'("A") + 8'd10;
      end
      return v[3:0];
   endfunction

   function automatic logic [7:0] upcase(logic [7:0] b);
      return (b inside {["a":"z"]}) ? b - 8'd32 : b;
   endfunction

   function automatic logic [POS_W-1:0] cap_pos(logic [POS_W:0] v);
      return (v > (POS_W + 1)'(MAX_LEN)) ? POS_W'(MAX_LEN) : v[POS_W-1:0];
   endfunction

   // True when an unquoted byte ends the token under the given options.
   function automatic logic stops(logic [7:0] b, logic [OPT_W-1:0] o);
      logic s;
      s = 1'b0;
      if (is_ws(b) && !o[OPT_KEEP_WS]) s = 1'b1;
      if ((b == CH_HASH) && !o[OPT_KEEP_HASH]) s = 1'b1;
      if ((b == CH_EQUALS) && o[OPT_STOP_EQUALS]) s = 1'b1;
      if ((b == CH_SEMI) && !o[OPT_KEEP_SEMI]) s = 1'b1;
      if (o[OPT_PATTERN_STOP] && ((b == CH_TILDE) || (b == CH_EQUALS) ||
                                  (b == CH_BANG) || (b == CH_PIPE))) s = 1'b1;
      return s;
   endfunction

   // Appends one result to a packet.
   function automatic packet_type add_result(packet_type pk, logic kind, logic [7:0] d,
                                             logic [POS_W-1:0] c);
      packet_type r;
      r = pk;
      if (r.count < RES_CNT_W'(MAX_RES)) begin
         r.res[r.count[RES_IDX_W-1:0]].kind = kind;
         r.res[r.count[RES_IDX_W-1:0]].data = d;
         r.res[r.count[RES_IDX_W-1:0]].consumed = c;
         r.count = r.count + RES_CNT_W'(1);
      end
      return r;
   endfunction

endpackage

/* rtl/core/cte_front.sv */
module cte_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_write_en,
   input  logic [cte_pkg::OPT_W-1:0] csr_write_data,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [7:0]                req_in_byte,
   input  logic                      req_in_last,
   input  logic                      queue_full,
   output logic                      push,
   output cte_pkg::packet_type       push_pkt
);
   import cte_pkg::*;

   logic [OPT_W-1:0] options_ff;
   phase_type        phase_ff, phase_in;
   quote_type        quote_ff, quote_in;
   logic [7:0]       held0_ff, held0_in;
   logic [7:0]       held1_ff, held1_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [POS_W-1:0] mark_ff, mark_in;
   logic [POS_W-1:0] p;
   logic             do_body;
   logic             do_trail;
   logic             accept;
   logic [13:0]      oct_sum;
   packet_type       pkt;
   logic [7:0]       b;

   assign b = req_in_byte;
   assign req_stall = queue_full;
   assign accept = req_valid && !req_stall;
   assign oct_sum = {held0_ff, 6'b0} + {3'b0, held1_ff, 3'b0} + {6'b0, b} - OCT_BIAS;

   // One source byte advances the parser and collects the results it causes.
   always_comb begin
      phase_in = phase_ff;
      quote_in = quote_ff;
      held0_in = held0_ff;
      held1_in = held1_ff;
      pos_in = pos_ff;
      mark_in = mark_ff;
      p = pos_ff;
      do_body = 1'b0;
      do_trail = 1'b0;
      pkt = '0;

      if (b != CH_NUL) begin
         if (pos_ff < POS_W'(MAX_LEN)) begin
            pos_in = pos_ff + POS_W'(1);
         end

         // Phases that consume the byte themselves or hand it on to the body.
         case (phase_ff)
            PH_LEAD: begin
               do_body = !is_ws(b);
            end
            PH_BODY: begin
               do_body = 1'b1;
            end
            PH_ESC: begin
               phase_in = PH_BODY;
               case (b)
                  "c", "C": phase_in = PH_CTRLC;
                  "r": pkt = add_result(pkt, KIND_DATA, CH_CR, '0);
                  "n": pkt = add_result(pkt, KIND_DATA, CH_LF, '0);
                  "t": pkt = add_result(pkt, KIND_DATA, CH_TAB, '0);
                  "f": pkt = add_result(pkt, KIND_DATA, CH_FF, '0);
                  "e", "E": pkt = add_result(pkt, KIND_DATA, CH_ESCAPE, '0);
                  "x": phase_in = PH_HEX1;
                  default: begin
                     if (is_dec(b)) begin
                        held0_in = b;
                        phase_in = PH_OCT1;
                     end else begin
                        pkt = add_result(pkt, KIND_DATA, b, '0);
                     end
                  end
               endcase
            end
            PH_CTRLC: begin
               pkt = add_result(pkt, KIND_DATA, (upcase(b) - CH_AT) & CTRL_MASK, '0);
               phase_in = PH_BODY;
            end
            PH_OCT1: begin
               if (is_oct(b)) begin
                  held1_in = b;
                  phase_in = PH_OCT2;
               end else begin
                  pkt = add_result(pkt, KIND_DATA, held0_ff, '0);
                  do_body = 1'b1;
               end
            end
            PH_OCT2: begin
               if (is_oct(b)) begin
                  pkt = add_result(pkt, KIND_DATA, oct_sum[7:0], '0);
                  phase_in = PH_BODY;
               end else begin
                  pkt = add_result(pkt, KIND_DATA, held0_ff, '0);
                  pkt = add_result(pkt, KIND_DATA, held1_ff, '0);
                  do_body = 1'b1;
               end
            end
            PH_HEX1: begin
               if (is_hex(b)) begin
                  held0_in = b;
                  phase_in = PH_HEX2;
               end else begin
                  pkt = add_result(pkt, KIND_DATA, CH_LOW_X, '0);
                  do_body = 1'b1;
               end
            end
            PH_HEX2: begin
               if (is_hex(b)) begin
                  pkt = add_result(pkt, KIND_DATA, {hex_val(held0_ff), hex_val(b)}, '0);
                  phase_in = PH_BODY;
               end else begin
                  pkt = add_result(pkt, KIND_DATA, CH_LOW_X, '0);
                  pkt = add_result(pkt, KIND_DATA, held0_ff, '0);
                  do_body = 1'b1;
               end
            end
            PH_CARET: begin
               if (b == CH_CARET) begin
                  pkt = add_result(pkt, KIND_DATA, CH_CARET, '0);
               end else if (b == CH_LBRACKET) begin
                  pkt = add_result(pkt, KIND_DATA, CH_ESCAPE, '0);
               end else if (is_alpha(b)) begin
                  pkt = add_result(pkt, KIND_DATA, upcase(b) - CH_AT, '0);
               end else begin
                  pkt = add_result(pkt, KIND_DATA, CH_CARET, '0);
                  pkt = add_result(pkt, KIND_DATA, b, '0);
               end
               phase_in = PH_BODY;
            end
            PH_TRAIL: begin
               do_trail = 1'b1;
            end
            PH_DONE: begin
               phase_in = PH_DONE;
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase

         // Token body: stop bytes, quotes, escape openers and plain data.
         if (do_body) begin
            phase_in = PH_BODY;
            if ((quote_ff == Q_NONE) && stops(b, options_ff)) begin
               mark_in = cap_pos({1'b0, p});
               phase_in = PH_TRAIL;
               do_trail = 1'b1;
            end else if (((quote_ff == Q_SINGLE) && (b == CH_SQUOTE)) ||
                         ((quote_ff == Q_DOUBLE) && (b == CH_DQUOTE))) begin
               quote_in = Q_NONE;
            end else if ((quote_ff == Q_NONE) && ((b == CH_SQUOTE) || (b == CH_DQUOTE)) &&
                         !options_ff[OPT_NO_QUOTES]) begin
               quote_in = (b == CH_SQUOTE) ? Q_SINGLE : Q_DOUBLE;
            end else if ((b == CH_BACKSLASH) && (quote_ff != Q_SINGLE)) begin
               phase_in = PH_ESC;
            end else if ((b == CH_CARET) && options_ff[OPT_CARET]) begin
               phase_in = PH_CARET;
            end else begin
               pkt = add_result(pkt, KIND_DATA, b, '0);
            end
         end

         // Whitespace after the stop byte moves the end mark on.
         if (do_trail) begin
            if (is_ws(b)) begin
               mark_in = cap_pos({1'b0, p} + (POS_W + 1)'(1));
            end else begin
               pkt = add_result(pkt, KIND_END, '0, mark_in);
               phase_in = PH_DONE;
            end
         end
      end

      // End of string: flush pending lookahead and report the consumed count.
      if ((b == CH_NUL) || req_in_last) begin
         if (phase_in == PH_TRAIL) begin
            pkt = add_result(pkt, KIND_END, '0, mark_in);
         end else if (phase_in != PH_DONE) begin
            if (phase_in == PH_OCT1) begin
               pkt = add_result(pkt, KIND_DATA, held0_in, '0);
            end else if (phase_in == PH_OCT2) begin
               pkt = add_result(pkt, KIND_DATA, held0_in, '0);
               pkt = add_result(pkt, KIND_DATA, held1_in, '0);
            end else if (phase_in == PH_HEX1) begin
               pkt = add_result(pkt, KIND_DATA, CH_LOW_X, '0);
            end else if (phase_in == PH_HEX2) begin
               pkt = add_result(pkt, KIND_DATA, CH_LOW_X, '0);
               pkt = add_result(pkt, KIND_DATA, held0_in, '0);
            end
            pkt = add_result(pkt, KIND_END, '0, pos_in);
         end
         if (req_in_last) begin
            phase_in = PH_LEAD;
            quote_in = Q_NONE;
            pos_in = '0;
            mark_in = '0;
         end else begin
            phase_in = PH_DONE;
         end
      end
   end

   assign push = accept && (pkt.count != '0);
   assign push_pkt = pkt;

   // Parser state and option register.
   always_ff @(posedge clock) begin
      if (reset) begin
         options_ff <= '0;
         phase_ff <= PH_LEAD;
         quote_ff <= Q_NONE;
         pos_ff <= '0;
         mark_ff <= '0;
      end else begin
         if (csr_write_en) begin
            options_ff <= csr_write_data;
         end
         if (accept) begin
            phase_ff <= phase_in;
            quote_ff <= quote_in;
            pos_ff <= pos_in;
            mark_ff <= mark_in;
         end
      end
   end

   // Held lookahead bytes carry no reset.
   always_ff @(posedge clock) begin
      if (accept) begin
         held0_ff <= held0_in;
         held1_ff <= held1_in;
      end
   end

endmodule

/* rtl/core/cte_queue.sv */
module cte_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  cte_pkg::packet_type push_pkt,
   input  logic                pop,
   output logic                full,
   output cte_pkg::head_type   head
);
   import cte_pkg::*;

   packet_type        mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QCNT_W-1:0] count_ff;

   assign full = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.pkt = mem_ff[rd_ptr_ff];

   // Packet storage.
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_pkt;
      end
   end

   // Pointers and fill level.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + QCNT_W'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - QCNT_W'(1);
         end
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full) else $error("packet transfer into a full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> head.valid) else $error("packet taken from an empty queue");

   a_packet_nonempty: assert property (@(posedge clock) disable iff (reset)
      push |-> (push_pkt.count != '0)) else $error("empty packet written to queue");

   a_fill_tracks: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + QCNT_W'(1)))
      else $error("queue fill level lost a packet");

endmodule

/* rtl/core/cte_back.sv */
module cte_back (
   input  logic                      clock,
   input  logic                      reset,
   input  cte_pkg::head_type         head,
   output logic                      pop,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic                      rsp_out_kind,
   output logic [7:0]                rsp_out_byte,
   output logic [cte_pkg::POS_W-1:0] rsp_consumed,
   output logic                      rsp_run_last
);
   import cte_pkg::*;

   logic [RES_IDX_W-1:0] idx_ff;
   logic                 xfer;
   result_type           cur;

   assign cur = head.pkt.res[idx_ff];
   assign rsp_valid = head.valid;
   assign rsp_out_kind = cur.kind;
   assign rsp_out_byte = cur.data;
   assign rsp_consumed = cur.consumed;
   assign rsp_run_last = ({1'b0, idx_ff} == (head.pkt.count - RES_CNT_W'(1)));
   assign xfer = rsp_valid && !rsp_stall;
   assign pop = xfer && rsp_run_last;

   // Walk through the results of the head packet, one per transfer.
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else if (xfer) begin
         if (rsp_run_last) begin
            idx_ff <= '0;
         end else begin
            idx_ff <= idx_ff + RES_IDX_W'(1);
         end
      end
   end

endmodule

/* rtl/core/config_token_unescaper.sv */
// A result is offered from the packet queue, which registers the packet at the source byte's transfer.
// One source byte is taken per cycle while the queue is not full; the output side sends one result
// per cycle while rsp_stall is low, so a byte causing n results (up to four) holds the output for n transfers.
// A four-packet queue between parser and output lets either side stall on its own.
// Reset (synchronous, active high) clears the options, the parser and the queue.
module config_token_unescaper (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_write_en,
   input  logic [cte_pkg::OPT_W-1:0] csr_write_data,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [7:0]                req_in_byte,
   input  logic                      req_in_last,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic                      rsp_out_kind,
   output logic [7:0]                rsp_out_byte,
   output logic [cte_pkg::POS_W-1:0] rsp_consumed,
   output logic                      rsp_run_last
);
   import cte_pkg::*;

   logic       push;
   logic       pop;
   logic       queue_full;
   packet_type push_pkt;
   head_type   head;

   // Parser: takes source bytes and builds result packets.
   cte_front u_front (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_in_byte    (req_in_byte),
      .req_in_last    (req_in_last),
      .queue_full     (queue_full),
      .push           (push),
      .push_pkt       (push_pkt)
   );

   // Packet queue between the two sides.
   cte_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_pkt (push_pkt),
      .pop      (pop),
      .full     (queue_full),
      .head     (head)
   );

   // Output side: sends the packet's results one at a time.
   cte_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head         (head),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_kind (rsp_out_kind),
      .rsp_out_byte (rsp_out_byte),
      .rsp_consumed (rsp_consumed),
      .rsp_run_last (rsp_run_last)
   );

endmodule

/* tb/sv/tb_config_token_unescaper.sv */
`timescale 1ns / 1ps

module tb_config_token_unescaper;
   import cte_pkg::*;

   // One result as it leaves the block.
   typedef struct packed {
      logic             kind;
      logic [7:0]       data;
      logic [POS_W-1:0] consumed;
      logic             run_last;
   } token_res_type;

   // One row of the directed part; typed rows carry their own expected result.
   typedef struct packed {
      logic [7:0]       b;
      logic             last;
      logic             typed;
      logic             has_res;
      logic             kind;
      logic [7:0]       data;
      logic [POS_W-1:0] consumed;
   } dir_row_type;

   localparam int DIR_N = 27;

   // Options are 0 throughout; positions count from the first byte.
   dir_row_type dir_rows [DIR_N] = '{
      '{CH_SPACE,     1'b0, 1'b1, 1'b0, KIND_DATA, 8'h00,        13'd0},
      '{CH_TAB,       1'b0, 1'b1, 1'b0, KIND_DATA, 8'h00,        13'd0},
      '{8'h41,        1'b0, 1'b1, 1'b1, KIND_DATA, 8'h41,        13'd0},
      '{CH_BACKSLASH, 1'b0, 1'b1, 1'b0, KIND_DATA, 8'h00,        13'd0},
      '{8'h6e,        1'b0, 1'b1, 1'b1, KIND_DATA, CH_LF,        13'd0},
      '{CH_BACKSLASH, 1'b0, 1'b1, 1'b0, KIND_DATA, 8'h00,        13'd0},
      '{8'h63,        1'b0, 1'b1, 1'b0, KIND_DATA, 8'h00,        13'd0},
      '{8'h61,        1'b0, 1'b1, 1'b1, KIND_DATA, 8'h01,        13'd0},
      '{CH_BACKSLASH, 1'b0, 1'b1, 1'b0, KIND_DATA, 8'h00,        13'd0},
      '{8'h31,        1'b0, 1'b1, 1'b0, KIND_DATA, 8'h00,        13'd0},
      '{8'h30,        1'b0, 1'b1, 1'b0, KIND_DATA, 8'h00,        13'd0},
      '{8'h31,        1'b0, 1'b1, 1'b1, KIND_DATA, 8'h41,        13'd0},
      '{CH_BACKSLASH, 1'b0, 1'b1, 1'b0, KIND_DATA, 8'h00,        13'd0},
      '{CH_LOW_X,     1'b0, 1'b1, 1'b0, KIND_DATA, 8'h00,        13'd0},
      '{8'h66,        1'b0, 1'b1, 1'b0, KIND_DATA, 8'h00,        13'd0},
      '{8'h46,        1'b0, 1'b1, 1'b1, KIND_DATA, 8'hff,        13'd0},
      '{CH_BACKSLASH, 1'b0, 1'b0, 1'b0, KIND_DATA, 8'h00,        13'd0},
      '{CH_LOW_X,     1'b0, 1'b0, 1'b0, KIND_DATA, 8'h00,        13'd0},
      '{8'h67,        1'b0, 1'b0, 1'b0, KIND_DATA, 8'h00,        13'd0},
      '{8'hff,        1'b0, 1'b1, 1'b1, KIND_DATA, 8'hff,        13'd0},
      '{CH_DQUOTE,    1'b0, 1'b1, 1'b0, KIND_DATA, 8'h00,        13'd0},
      '{CH_SPACE,     1'b0, 1'b1, 1'b1, KIND_DATA, CH_SPACE,     13'd0},
      '{CH_DQUOTE,    1'b0, 1'b1, 1'b0, KIND_DATA, 8'h00,        13'd0},
      '{CH_SEMI,      1'b0, 1'b1, 1'b1, KIND_END,  8'h00,        13'd23},
      '{CH_SPACE,     1'b1, 1'b1, 1'b0, KIND_DATA, 8'h00,        13'd0},
      '{8'h01,        1'b1, 1'b0, 1'b0, KIND_DATA, 8'h00,        13'd0},
      '{CH_NUL,       1'b1, 1'b1, 1'b1, KIND_END,  8'h00,        13'd0}
   };

   logic                 clock;
   logic                 reset;
   logic                 csr_write_en;
   logic [OPT_W-1:0]     csr_write_data;
   logic                 req_valid;
   logic                 req_stall;
   logic [7:0]           req_in_byte;
   logic                 req_in_last;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic                 rsp_out_kind;
   logic [7:0]           rsp_out_byte;
   logic [POS_W-1:0]     rsp_consumed;
   logic                 rsp_run_last;

   // Shadow copy of the parser state and the option register.
   logic [OPT_W-1:0]     opts;
   phase_type            parse_ph;
   quote_type            quote_st;
   logic [7:0]           held_a;
   logic [7:0]           held_b;
   logic [POS_W-1:0]     src_pos;
   logic [POS_W-1:0]     stop_mark;

   token_res_type        step_res[$];
   token_res_type        decoded_q[$];
   int                   mismatches;
   int                   sent_items;
   logic                 idle_on;

   config_token_unescaper dut (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_in_byte    (req_in_byte),
      .req_in_last    (req_in_last),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_kind   (rsp_out_kind),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_consumed   (rsp_consumed),
      .rsp_run_last   (rsp_run_last)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Character classes used by the predictor.
   function automatic logic blank(logic [7:0] b);
      return (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
   endfunction

   function automatic int nibble(logic [7:0] b);
      if (b >= 8'h30 && b <= 8'h39) return int'(b) - 'h30;
      if (b >= 8'h61 && b <= 8'h66) return int'(b) - 'h61 + 10;
      if (b >= 8'h41 && b <= 8'h46) return int'(b) - 'h41 + 10;
      return -1;
   endfunction

   function automatic logic [7:0] to_upper(logic [7:0] b);
      return (b >= 8'h61 && b <= 8'h7a) ? b - 8'd32 : b;
   endfunction

   function automatic logic [POS_W-1:0] clamp_pos(int v);
      return (v > MAX_LEN) ? POS_W'(MAX_LEN) : POS_W'(v);
   endfunction

   function automatic void emit(logic kind, logic [7:0] d, logic [POS_W-1:0] c);
      if (step_res.size() < MAX_RES) step_res.push_back('{kind, d, c, 1'b0});
   endfunction

   function automatic logic ends_token(logic [7:0] b);
      if (blank(b) && !opts[OPT_KEEP_WS]) return 1'b1;
      if (b == CH_HASH && !opts[OPT_KEEP_HASH]) return 1'b1;
      if (b == CH_EQUALS && opts[OPT_STOP_EQUALS]) return 1'b1;
      if (b == CH_SEMI && !opts[OPT_KEEP_SEMI]) return 1'b1;
      if (opts[OPT_PATTERN_STOP] &&
          (b == CH_TILDE || b == CH_EQUALS || b == CH_BANG || b == CH_PIPE)) return 1'b1;
      return 1'b0;
   endfunction

   // After a stop byte, whitespace extends the count; anything else closes the token.
   function automatic void after_stop(logic [7:0] b, int p);
      if (blank(b)) begin
         stop_mark = clamp_pos(p + 1);
      end else begin
         emit(KIND_END, 8'h00, stop_mark);
         parse_ph = PH_DONE;
      end
   endfunction

   function automatic void take_body(logic [7:0] b, int p);
      parse_ph = PH_BODY;
      if (quote_st == Q_NONE && ends_token(b)) begin
         stop_mark = clamp_pos(p);
         parse_ph = PH_TRAIL;
         after_stop(b, p);
         return;
      end
      if ((quote_st == Q_SINGLE && b == CH_SQUOTE) ||
          (quote_st == Q_DOUBLE && b == CH_DQUOTE)) begin
         quote_st = Q_NONE;
      end else if (quote_st == Q_NONE && (b == CH_SQUOTE || b == CH_DQUOTE) &&
                   !opts[OPT_NO_QUOTES]) begin
         quote_st = (b == CH_SQUOTE) ? Q_SINGLE : Q_DOUBLE;
      end else if (b == CH_BACKSLASH && quote_st != Q_SINGLE) begin
         parse_ph = PH_ESC;
      end else if (b == CH_CARET && opts[OPT_CARET]) begin
         parse_ph = PH_CARET;
      end else begin
         emit(KIND_DATA, b, '0);
      end
   endfunction

   // A failed lookahead gives back the bytes it was holding as plain data.
   function automatic void give_back();
      case (parse_ph)
         PH_OCT1: emit(KIND_DATA, held_a, '0);
         PH_OCT2: begin
            emit(KIND_DATA, held_a, '0);
            emit(KIND_DATA, held_b, '0);
         end
         PH_HEX1: emit(KIND_DATA, CH_LOW_X, '0);
         PH_HEX2: begin
            emit(KIND_DATA, CH_LOW_X, '0);
            emit(KIND_DATA, held_a, '0);
         end
         default: ;
      endcase
      parse_ph = PH_BODY;
   endfunction

   function automatic void first_after_backslash(logic [7:0] b);
      parse_ph = PH_BODY;
      case (b)
         "c", "C": parse_ph = PH_CTRLC;
         "r": emit(KIND_DATA, CH_CR, '0);
         "n": emit(KIND_DATA, CH_LF, '0);
         "t": emit(KIND_DATA, CH_TAB, '0);
         "f": emit(KIND_DATA, CH_FF, '0);
         "e", "E": emit(KIND_DATA, CH_ESCAPE, '0);
         CH_LOW_X: parse_ph = PH_HEX1;
         default: begin
            if (b >= 8'h30 && b <= 8'h39) begin
               held_a = b;
               parse_ph = PH_OCT1;
            end else begin
               emit(KIND_DATA, b, '0);
            end
         end
      endcase
   endfunction

   function automatic void feed(logic [7:0] b, int p);
      int v;
      case (parse_ph)
         PH_LEAD: if (!blank(b)) take_body(b, p);
         PH_BODY: take_body(b, p);
         PH_ESC: first_after_backslash(b);
         PH_CTRLC: begin
            emit(KIND_DATA, (to_upper(b) - CH_AT) & CTRL_MASK, '0);
            parse_ph = PH_BODY;
         end
         PH_OCT1: begin
            if (b >= 8'h30 && b <= 8'h37) begin
               held_b = b;
               parse_ph = PH_OCT2;
            end else begin
               give_back();
               take_body(b, p);
            end
         end
         PH_OCT2: begin
            if (b >= 8'h30 && b <= 8'h37) begin
               v = int'(held_a) * 64 + int'(held_b) * 8 + int'(b) - int'(OCT_BIAS);
               emit(KIND_DATA, 8'(v & 'hff), '0);
               parse_ph = PH_BODY;
            end else begin
               give_back();
               take_body(b, p);
            end
         end
         PH_HEX1: begin
            if (nibble(b) >= 0) begin
               held_a = b;
               parse_ph = PH_HEX2;
            end else begin
               give_back();
               take_body(b, p);
            end
         end
         PH_HEX2: begin
            if (nibble(b) >= 0) begin
               emit(KIND_DATA, 8'(nibble(held_a) * 16 + nibble(b)), '0);
               parse_ph = PH_BODY;
            end else begin
               give_back();
               take_body(b, p);
            end
         end
         PH_CARET: begin
            if (b == CH_CARET) begin
               emit(KIND_DATA, CH_CARET, '0);
            end else if (b == CH_LBRACKET) begin
               emit(KIND_DATA, CH_ESCAPE, '0);
            end else if ((b >= 8'h61 && b <= 8'h7a) || (b >= 8'h41 && b <= 8'h5a)) begin
               emit(KIND_DATA, to_upper(b) - CH_AT, '0);
            end else begin
               emit(KIND_DATA, CH_CARET, '0);
               emit(KIND_DATA, b, '0);
            end
            parse_ph = PH_BODY;
         end
         PH_TRAIL: after_stop(b, p);
         default: ;
      endcase
   endfunction

   // End of string: report once, then either re-arm or ignore bytes until the last flag.
   function automatic void close_string(logic last);
      if (parse_ph == PH_TRAIL) begin
         emit(KIND_END, 8'h00, stop_mark);
      end else if (parse_ph != PH_DONE) begin
         give_back();
         emit(KIND_END, 8'h00, src_pos);
      end
      if (last) begin
         parse_ph = PH_LEAD;
         quote_st = Q_NONE;
         src_pos = '0;
         stop_mark = '0;
      end else begin
         parse_ph = PH_DONE;
      end
   endfunction

   // Works out the results that one source byte causes, into step_res.
   function automatic void unescape_byte(logic [7:0] b, logic last);
      token_res_type r;
      int p;
      step_res = {};
      if (b == CH_NUL) begin
         close_string(last);
      end else begin
         p = int'(src_pos);
         if (int'(src_pos) < MAX_LEN) src_pos = src_pos + POS_W'(1);
         feed(b, p);
         if (last) close_string(1'b1);
      end
      if (step_res.size() > 0) begin
         r = step_res.pop_back();
         r.run_last = 1'b1;
         step_res.push_back(r);
      end
   endfunction

   // Presents one byte and holds it until its transfer; called at a rising edge.
   task automatic drive_byte(input logic [7:0] b, input logic last);
      while (idle_on && $urandom_range(0, 99) < 30) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_in_byte <= b;
      req_in_last <= last;
      do @(posedge clock); while (req_stall);
      sent_items++;
   endtask

   task automatic send_byte(input logic [7:0] b, input logic last);
      unescape_byte(b, last);
      foreach (step_res[k]) decoded_q.push_back(step_res[k]);
      drive_byte(b, last);
   endtask

   // Stops the sender until every expected result has come and the block is quiet.
   task automatic settle();
      req_valid <= 1'b0;
      while (decoded_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic set_options(input logic [OPT_W-1:0] v);
      settle();
      csr_write_en <= 1'b1;
      csr_write_data <= v;
      @(posedge clock);
      csr_write_en <= 1'b0;
      opts = v;
   endtask

   function automatic logic [7:0] pick(string set);
      return set[$urandom_range(0, set.len() - 1)];
   endfunction

   function automatic logic [7:0] pick_ws();
      return $urandom_range(0, 1) ? CH_SPACE : 8'($urandom_range(9, 13));
   endfunction

   // Builds one string: mostly well-formed tokens with random content, sometimes noise.
   function automatic void build_string(ref logic [7:0] s[$]);
      string hexd = "0123456789abcdefABCDEF";
      string octd = "01234567";
      int n;
      s = {};
      if ($urandom_range(0, 9) < 2) begin
         repeat ($urandom_range(1, 8)) s.push_back(8'($urandom_range(0, 255)));
         return;
      end
      repeat ($urandom_range(0, 2)) s.push_back(pick_ws());
      n = $urandom_range(1, 6);
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(0, 15))
            0, 1: s.push_back(8'($urandom_range(33, 126)));
            2: begin
               s.push_back(CH_BACKSLASH);
               s.push_back(pick("rntfeEqQ#"));
            end
            3: begin
               s.push_back(CH_BACKSLASH);
               s.push_back(pick("cC"));
               s.push_back(8'($urandom_range(1, 255)));
            end
            4: begin
               s.push_back(CH_BACKSLASH);
               s.push_back(pick("0123456789"));
               s.push_back(pick(octd));
               s.push_back(pick(octd));
            end
            5: begin
               s.push_back(CH_BACKSLASH);
               s.push_back(pick("0123456789"));
               if ($urandom_range(0, 1)) s.push_back(pick(octd));
               s.push_back(pick("89aZ ;x"));
            end
            6: begin
               s.push_back(CH_BACKSLASH);
               s.push_back(CH_LOW_X);
               s.push_back(pick(hexd));
               s.push_back(pick(hexd));
            end
            7: begin
               s.push_back(CH_BACKSLASH);
               s.push_back(CH_LOW_X);
               if ($urandom_range(0, 1)) s.push_back(pick(hexd));
               s.push_back(pick("gGzZ -/:@;"));
            end
            8: begin
               s.push_back(CH_CARET);
               s.push_back(pick("^^[[amZQ?1 "));
            end
            9: begin
               s.push_back(CH_SQUOTE);
               repeat ($urandom_range(0, 3)) s.push_back(pick("a \\\"#;"));
               s.push_back(CH_SQUOTE);
            end
            10: begin
               s.push_back(CH_DQUOTE);
               repeat ($urandom_range(0, 3)) s.push_back(pick("b \\'#^="));
               s.push_back(CH_DQUOTE);
            end
            11: begin
               s.push_back(pick(" #;=~!|\t"));
               repeat ($urandom_range(0, 3)) s.push_back(pick_ws());
            end
            12: s.push_back(8'($urandom_range(1, 255)));
            13: s.push_back(8'($urandom_range(128, 255)));
            14: s.push_back(pick_ws());
            default: s.push_back(pick("\\^"));
         endcase
      end
      repeat ($urandom_range(0, 2)) s.push_back(pick_ws());
   endfunction

   // Sends a string with one of the ways a string can end.
   task automatic send_string(input logic [7:0] s[$]);
      int mode;
      mode = $urandom_range(0, 9);
      foreach (s[i]) send_byte(s[i], (mode < 7) && (i == s.size() - 1));
      if (mode == 7) begin
         send_byte(CH_NUL, 1'b1);
      end else if (mode > 7) begin
         send_byte(CH_NUL, 1'b0);
         repeat ($urandom_range(0, 3)) send_byte(8'($urandom_range(0, 255)), 1'b0);
         send_byte(8'($urandom_range(0, 255)), 1'b1);
      end
   endtask

   // Result side: random stall, and each transfer checked against the oldest expectation.
   always @(posedge clock) begin
      token_res_type want;
      rsp_stall <= idle_on && ($urandom_range(0, 99) < 30);
      if (!reset && rsp_valid && !rsp_stall) begin
         if (decoded_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: kind %0d byte %02h consumed %0d last %0d",
                        rsp_out_kind, rsp_out_byte, rsp_consumed, rsp_run_last);
         end else begin
            want = decoded_q.pop_front();
            if ({rsp_out_kind, rsp_out_byte, rsp_consumed, rsp_run_last} !== want) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $write("mismatch: expected kind %0d byte %02h consumed %0d last %0d, ",
                         want.kind, want.data, want.consumed, want.run_last);
                  $display("got kind %0d byte %02h consumed %0d last %0d",
                           rsp_out_kind, rsp_out_byte, rsp_consumed, rsp_run_last);
               end
            end
         end
      end
   end

   // Guard against a hung handshake.
   initial begin
      #4_000_000;
      $display("[config_token_unescaper] ERROR");
      $finish;
   end

   initial begin
      logic [7:0]       text[$];
      logic [OPT_W-1:0] v;
      int               start;
      clock = 1'b0;
      reset = 1'b1;
      csr_write_en = 1'b0;
      csr_write_data = '0;
      req_valid = 1'b0;
      req_in_byte = '0;
      req_in_last = 1'b0;
      rsp_stall = 1'b0;
      idle_on = 1'b1;
      mismatches = 0;
      sent_items = 0;
      opts = '0;
      parse_ph = PH_LEAD;
      quote_st = Q_NONE;
      held_a = '0;
      held_b = '0;
      src_pos = '0;
      stop_mark = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed part under the reset options.
      foreach (dir_rows[i]) begin
         unescape_byte(dir_rows[i].b, dir_rows[i].last);
         if (!dir_rows[i].typed) begin
            foreach (step_res[k]) decoded_q.push_back(step_res[k]);
         end else if (dir_rows[i].has_res) begin
            decoded_q.push_back('{dir_rows[i].kind, dir_rows[i].data,
                                  dir_rows[i].consumed, 1'b1});
         end
         drive_byte(dir_rows[i].b, dir_rows[i].last);
      end

      // Random part over several option settings; the third runs with no idling.
      for (int ph_i = 0; ph_i < 7; ph_i++) begin
         case (ph_i)
            0: v = 7'h00;
            1: v = 7'h7f;
            2: v = 7'h40;
            3: v = 7'h20;
            4: v = 7'h55;
            default: v = 7'($urandom_range(0, 127));
         endcase
         set_options(v);
         idle_on = (ph_i != 2);
         start = sent_items;
         while (sent_items - start < 58) begin
            build_string(text);
            send_string(text);
            if ($urandom_range(0, 9) == 0) settle();
         end
      end
      idle_on = 1'b1;

      req_valid <= 1'b0;
      while (decoded_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatches == 0) begin
         $display("[config_token_unescaper] OK");
      end else begin
         $display("[config_token_unescaper] ERROR");
      end
      $finish;
   end

endmodule
